FILE: sv/enhanced_clock_tlb_replacement_core_assert.svh
// Assertion macros used by the replacement core RTL.
`ifndef ENHANCED_CLOCK_TLB_REPLACEMENT_CORE_ASSERT_SVH
`define ENHANCED_CLOCK_TLB_REPLACEMENT_CORE_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define ECTR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ectr: same-cycle check failed");

// Consequence must hold in the cycle after the antecedent.
`define ECTR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ectr: next-cycle check failed");

`endif

FILE: sv/ectr_pkg.sv
// Shared types and codes for the clock TLB replacement core.
package ectr_pkg;

    // Width of a TLB entry number.
    localparam int ENTRY_W = 4;

    // Request kinds carried in the input item.
    localparam logic [2:0] KIND_INSERT  = 3'd0;
    localparam logic [2:0] KIND_USE     = 3'd1;
    localparam logic [2:0] KIND_DIRTY   = 3'd2;
    localparam logic [2:0] KIND_REMOVE  = 3'd3;
    localparam logic [2:0] KIND_REPLACE = 3'd4;
    localparam logic [2:0] KIND_EVICT   = 3'd5;

    // Queue operations issued by the sequencer.
    localparam logic [1:0] QOP_NONE   = 2'd0;
    localparam logic [1:0] QOP_ROTATE = 2'd1;
    localparam logic [1:0] QOP_POP    = 2'd2;
    localparam logic [1:0] QOP_PUSH   = 2'd3;

    // Command from the sequencer to the order queue.
    typedef struct packed {
        logic [1:0]         op;
        logic [ENTRY_W-1:0] data;
    } ectr_qcmd_t;

endpackage

FILE: sv/enhanced_clock_tlb_replacement_core.sv
// Top level of the enhanced second-chance clock replacement core for TLB entries.
// Use, dirty and unused kinds pass from the idle state straight to the finish state; insert and
// remove walk the queue in the scan state, one rotation or pop per cycle past the single head compare.
// Replace and evict run the clock hand, one head entry examined per cycle.
// Throughput: one item at a time; the next item is taken once the sequencer is idle.
// Reset: synchronous active-low aresetn empties the queue and clears all bits at once.
`include "enhanced_clock_tlb_replacement_core_assert.svh"

module enhanced_clock_tlb_replacement_core
    import ectr_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // kind[2:0], entry_index[6:3], zero[7]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // victim_index[3:0], found[4], occupancy[9:5], zero[15:10]
);

    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int IW    = $clog2(ENTRIES);
    localparam int GUARD = 2 * ENTRIES + 2;
    localparam int GW    = $clog2(GUARD + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_CLOCK  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [2:0]         kind_reg, kind_next;
    logic [ENTRY_W-1:0] idx_reg, idx_next;
    logic               hit_reg, hit_next;
    logic [GW-1:0]      step_reg, step_next;
    logic [ENTRY_W-1:0] victim_reg, victim_next;
    logic               found_reg, found_next;
    logic [ENTRIES-1:0] ref_reg, ref_next;
    logic [ENTRIES-1:0] mod_reg, mod_next;
    logic               m_valid_reg, m_valid_next;
    logic [9:0]         m_data_reg, m_data_next;

    logic [2:0]         s_kind;
    logic [ENTRY_W-1:0] s_entry;
    logic               s_idx_ok;
    logic               idx_ok;
    logic [IW-1:0]      s_bit;
    logic [IW-1:0]      idx_bit;
    logic [IW-1:0]      head_bit;
    logic               match;

    ectr_qcmd_t         q_cmd;
    logic [ENTRY_W-1:0] q_head;
    logic [CW-1:0]      q_count;

    ectr_queue #(
        .ENTRIES (ENTRIES)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (q_cmd),
        .head    (q_head),
        .count   (q_count)
    );

    // Unpack the input item.
    assign s_kind   = s_tdata[2:0];
    assign s_entry  = s_tdata[6:3];
    assign s_idx_ok = (int'(s_entry) < ENTRIES);
    assign idx_ok   = (int'(idx_reg) < ENTRIES);
    assign s_bit    = IW'(s_entry);
    assign idx_bit  = IW'(idx_reg);
    assign head_bit = IW'(q_head);
    assign match    = (q_head == idx_reg) && !hit_reg;

    assign s_tready = (state_reg == ST_IDLE);

    // Sequencer: at most one queue operation per cycle around the shared head compare.
    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        idx_next     = idx_reg;
        hit_next     = hit_reg;
        step_next    = step_reg;
        victim_next  = victim_reg;
        found_next   = found_reg;
        ref_next     = ref_reg;
        mod_next     = mod_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        q_cmd.op     = QOP_NONE;
        q_cmd.data   = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next   = s_kind;
                    idx_next    = s_entry;
                    hit_next    = 1'b0;
                    found_next  = 1'b0;
                    victim_next = '0;
                    state_next  = ST_FINISH;
                    case (s_kind)
                        KIND_INSERT, KIND_REMOVE: begin
                            if (s_idx_ok) begin
                                step_next  = GW'(q_count);
                                state_next = ST_SCAN;
                            end
                        end
                        KIND_USE: begin
                            if (s_idx_ok) begin
                                ref_next[s_bit] = 1'b1;
                            end
                        end
                        KIND_DIRTY: begin
                            if (s_idx_ok) begin
                                mod_next[s_bit] = 1'b1;
                            end
                        end
                        KIND_REPLACE, KIND_EVICT: begin
                            if (q_count != '0) begin
                                step_next  = GW'(GUARD);
                                state_next = ST_CLOCK;
                            end
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            // Walk the whole queue once; a remove drops the entry as it passes the head.
            ST_SCAN: begin
                if (step_reg != '0) begin
                    step_next = step_reg - 1'b1;
                    hit_next  = hit_reg || match;
                    if (kind_reg == KIND_REMOVE && match) begin
                        q_cmd.op = QOP_POP;
                    end else begin
                        q_cmd.op = QOP_ROTATE;
                    end
                end else begin
                    if (kind_reg == KIND_INSERT && !hit_reg && idx_ok
                            && int'(q_count) < ENTRIES) begin
                        q_cmd.op          = QOP_PUSH;
                        q_cmd.data        = idx_reg;
                        ref_next[idx_bit] = 1'b0;
                        mod_next[idx_bit] = 1'b0;
                    end
                    state_next = ST_FINISH;
                end
            end

            // Clock hand: age the head entry or take it as the victim.
            ST_CLOCK: begin
                if (step_reg != '0) begin
                    step_next = step_reg - 1'b1;
                    if (!ref_reg[head_bit] && !mod_reg[head_bit]) begin
                        victim_next = q_head;
                        found_next  = 1'b1;
                        q_cmd.op    = (kind_reg == KIND_REPLACE) ? QOP_ROTATE : QOP_POP;
                        state_next  = ST_FINISH;
                    end else begin
                        ref_next[head_bit] = 1'b0;
                        if (!(ref_reg[head_bit] && mod_reg[head_bit])) begin
                            mod_next[head_bit] = 1'b0;
                        end
                        q_cmd.op = QOP_ROTATE;
                    end
                end else begin
                    state_next = ST_FINISH;
                end
            end

            // Hand the result item to the output register once it is free.
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_next  = {5'(q_count), found_reg, victim_reg};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and bit arrays.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ref_reg     <= '0;
            mod_reg     <= '0;
            m_valid_reg <= 1'b0;
            hit_reg     <= 1'b0;
            found_reg   <= 1'b0;
            step_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            ref_reg     <= ref_next;
            mod_reg     <= mod_next;
            m_valid_reg <= m_valid_next;
            hit_reg     <= hit_next;
            found_reg   <= found_next;
            step_reg    <= step_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        idx_reg    <= idx_next;
        victim_reg <= victim_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_data_reg};

    // The queue never holds more entries than it has slots.
    `ECTR_ASSERT_SAME(a_count_bound, 1'b1, int'(q_count) <= ENTRIES)
    // A scan step either keeps the fill count or drops it by one.
    `ECTR_ASSERT_NEXT(a_scan_count, (state_reg == ST_SCAN) && (step_reg != '0),
        (q_count == $past(q_count)) || (q_count == $past(q_count) - 1'b1))
    // The clock hand only clears reference and modified bits.
    `ECTR_ASSERT_NEXT(a_clock_clears, state_reg == ST_CLOCK,
        ((ref_reg & ~$past(ref_reg)) == '0) && ((mod_reg & ~$past(mod_reg)) == '0))
    // A result item appears only out of the finish step.
    `ECTR_ASSERT_NEXT(a_result_source, !m_valid_reg && (state_reg != ST_FINISH), !m_valid_reg)

endmodule

FILE: sv/ectr_queue.sv
// Replacement order queue: a shift line of entry numbers with head at slot zero.
module ectr_queue
    import ectr_pkg::*;
#(
    parameter int ENTRIES = 16,
    localparam int CW = $clog2(ENTRIES + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ectr_qcmd_t         cmd,
    output logic [ENTRY_W-1:0] head,
    output logic [CW-1:0]      count
);

    localparam int SW = $clog2(ENTRIES);

    logic [ENTRY_W-1:0] slot_reg [ENTRIES];
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      last_pos;
    logic               room;

    assign last_pos = count_reg - 1'b1;
    assign room     = (int'(count_reg) < ENTRIES);

    // Fill count follows pops and pushes.
    always_comb begin
        count_next = count_reg;
        case (cmd.op)
            QOP_POP: begin
                count_next = count_reg - 1'b1;
            end
            QOP_PUSH: begin
                if (room) begin
                    count_next = count_reg + 1'b1;
                end
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Slots shift toward the head; rotation wraps the head into the last valid slot.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            case (cmd.op)
                QOP_ROTATE: begin
                    if (CW'(i) == last_pos) begin
                        slot_reg[SW'(i)] <= slot_reg[0];
                    end else begin
                        slot_reg[SW'(i)] <= slot_reg[SW'((i + 1) % ENTRIES)];
                    end
                end
                QOP_POP: begin
                    slot_reg[SW'(i)] <= slot_reg[SW'((i + 1) % ENTRIES)];
                end
                QOP_PUSH: begin
                    if (room && CW'(i) == count_reg) begin
                        slot_reg[SW'(i)] <= cmd.data;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign head  = slot_reg[0];
    assign count = count_reg;

endmodule

FILE: sim/enhanced_clock_tlb_replacement_core_checker.sv
// Checker that predicts and compares every result of the clock TLB replacement core.
module enhanced_clock_tlb_replacement_core_checker
    import ectr_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // kind[2:0], entry_index[6:3], zero[7]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // victim_index[3:0], found[4], occupancy[9:5], zero[15:10]
    output int          mismatch_count,
    output int          pending_count
);

    // One result item as the block reports it.
    typedef struct packed {
        logic [ENTRY_W-1:0] victim;
        logic               found;
        logic [4:0]         occupancy;
    } replacement_t;

    // Predicted replacement order and per-entry flags.
    logic [ENTRY_W-1:0] order_slots [ENTRIES];
    int                 slot_count;
    logic [ENTRIES-1:0] ref_flags;
    logic [ENTRIES-1:0] mod_flags;

    replacement_t expected_results [$];
    int           errors;

    // Close the gap left by the slot at pos.
    function automatic void drop_slot(input int pos);
        for (int i = pos + 1; i < slot_count; i++) begin
            order_slots[i - 1] = order_slots[i];
        end
        slot_count--;
    endfunction

    // Apply one request to the predicted state and return the result it gives.
    function automatic replacement_t predict_replacement(input logic [2:0] kind,
                                                         input logic [ENTRY_W-1:0] entry);
        replacement_t       res;
        int                 pos;
        int                 guard;
        logic               hit;
        logic [ENTRY_W-1:0] head;
        res = '0;
        pos = -1;
        for (int i = 0; i < slot_count; i++) begin
            if (pos < 0 && order_slots[i] == entry) pos = i;
        end
        case (kind)
            KIND_INSERT: begin
                // A queued entry is never inserted a second time.
                if (pos < 0 && slot_count < ENTRIES) begin
                    order_slots[slot_count] = entry;
                    slot_count++;
                    ref_flags[entry] = 1'b0;
                    mod_flags[entry] = 1'b0;
                end
            end
            KIND_USE:    ref_flags[entry] = 1'b1;
            KIND_DIRTY:  mod_flags[entry] = 1'b1;
            KIND_REMOVE: begin
                if (pos >= 0) drop_slot(pos);
            end
            KIND_REPLACE, KIND_EVICT: begin
                hit = 1'b0;
                guard = 0;
                head = '0;
                // Rotate flagged heads to the tail until a clean one turns up.
                while (slot_count > 0 && !hit && guard < 2 * ENTRIES + 2) begin
                    head = order_slots[0];
                    if (!ref_flags[head] && !mod_flags[head]) begin
                        hit = 1'b1;
                    end else begin
                        if (!(ref_flags[head] && mod_flags[head])) mod_flags[head] = 1'b0;
                        ref_flags[head] = 1'b0;
                        drop_slot(0);
                        order_slots[slot_count] = head;
                        slot_count++;
                    end
                    guard++;
                end
                if (hit) begin
                    drop_slot(0);
                    res.victim = head;
                    res.found = 1'b1;
                    // Replace puts the victim back at the tail with clean flags.
                    if (kind == KIND_REPLACE) begin
                        order_slots[slot_count] = head;
                        slot_count++;
                        ref_flags[head] = 1'b0;
                        mod_flags[head] = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        res.occupancy = slot_count[4:0];
        return res;
    endfunction

    // Watch both channels: predict on each accepted request, compare each result.
    always @(posedge aclk) begin
        replacement_t seen;
        replacement_t want;
        if (!aresetn) begin
            slot_count = 0;
            ref_flags = '0;
            mod_flags = '0;
            expected_results.delete();
            errors = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_replacement(s_tdata[2:0], s_tdata[6:3]));
            end
            if (m_tvalid && m_tready) begin
                seen.victim = m_tdata[3:0];
                seen.found = m_tdata[4];
                seen.occupancy = m_tdata[9:5];
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected: victim %0d found %0d occ %0d",
                             $time, seen.victim, seen.found, seen.occupancy);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (seen.victim !== want.victim) begin
                        $display("%0t: victim_index expected %0d actual %0d",
                                 $time, want.victim, seen.victim);
                        errors++;
                    end
                    if (seen.found !== want.found) begin
                        $display("%0t: found expected %0d actual %0d",
                                 $time, want.found, seen.found);
                        errors++;
                    end
                    if (seen.occupancy !== want.occupancy) begin
                        $display("%0t: occupancy expected %0d actual %0d",
                                 $time, want.occupancy, seen.occupancy);
                        errors++;
                    end
                end
            end
        end
        mismatch_count <= errors;
        pending_count <= expected_results.size();
    end

endmodule

FILE: sim/enhanced_clock_tlb_replacement_core_tb.sv
// Testbench top: drives requests into the replacement core and reports the verdict.
module enhanced_clock_tlb_replacement_core_tb;
    import ectr_pkg::*;

    localparam int ENTRIES      = 16;
    localparam int RANDOM_ITEMS = 800;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 40;

    // Kind codes the block leaves unused.
    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;

    // Traffic mixes for blocks of random requests.
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // kind[2:0], entry_index[6:3], zero[7]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // victim_index[3:0], found[4], occupancy[9:5], zero[15:10]

    int mismatch_count;
    int pending_count;
    int tx_idle_pct;
    int rx_idle_pct;
    int sent_items;
    int stall_cycles;

    enhanced_clock_tlb_replacement_core #(.ENTRIES(ENTRIES)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    enhanced_clock_tlb_replacement_core_checker #(.ENTRIES(ENTRIES)) checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // Clock.
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Receiver backpressure.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Watchdog: too many cycles without any item moving ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Idle percentages follow the progress through the stimulus.
    function automatic void set_idling(input int n);
        if (n < (RANDOM_ITEMS + 22) / 3) begin
            tx_idle_pct = 24;
            rx_idle_pct = 47;
        end else if (n < 2 * (RANDOM_ITEMS + 22) / 3) begin
            tx_idle_pct = 47;
            rx_idle_pct = 24;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endfunction

    // Offer one request and hold it until the block takes it.
    task automatic send_request(input logic [2:0] kind, input logic [ENTRY_W-1:0] entry);
        set_idling(sent_items);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, entry, kind};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_items++;
    endtask

    // Pick a request kind according to the traffic mix.
    function automatic logic [2:0] pick_kind(input int mode);
        int roll;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_FILL: begin
                if (roll < 55) return KIND_INSERT;
                if (roll < 70) return KIND_USE;
                if (roll < 82) return KIND_DIRTY;
                if (roll < 86) return KIND_REMOVE;
                if (roll < 93) return KIND_REPLACE;
                if (roll < 99) return KIND_EVICT;
            end
            MODE_DRAIN: begin
                if (roll < 15) return KIND_INSERT;
                if (roll < 30) return KIND_USE;
                if (roll < 45) return KIND_DIRTY;
                if (roll < 55) return KIND_REMOVE;
                if (roll < 70) return KIND_REPLACE;
                if (roll < 98) return KIND_EVICT;
            end
            default: begin
                if (roll < 30) return KIND_INSERT;
                if (roll < 50) return KIND_USE;
                if (roll < 68) return KIND_DIRTY;
                if (roll < 76) return KIND_REMOVE;
                if (roll < 86) return KIND_REPLACE;
                if (roll < 97) return KIND_EVICT;
            end
        endcase
        return roll[0] ? KIND_SPARE_A : KIND_SPARE_B;
    endfunction

    // Stimulus and verdict.
    initial begin
        int mode;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        sent_items = 0;
        tx_idle_pct = 24;
        rx_idle_pct = 47;
        mode = MODE_MIXED;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty queue, spare kinds, then a small queue with flags set.
        send_request(KIND_REPLACE, 4'd0);
        send_request(KIND_EVICT, 4'd0);
        send_request(KIND_SPARE_A, 4'd15);
        send_request(KIND_SPARE_B, 4'd15);
        send_request(KIND_INSERT, 4'd0);
        send_request(KIND_INSERT, 4'd15);
        send_request(KIND_INSERT, 4'd10);
        send_request(KIND_INSERT, 4'd5);
        send_request(KIND_INSERT, 4'd0);
        send_request(KIND_USE, 4'd15);
        send_request(KIND_DIRTY, 4'd15);
        send_request(KIND_DIRTY, 4'd10);
        send_request(KIND_USE, 4'd5);
        // Flag and removal of an entry that is not queued, then removal of a queued one.
        send_request(KIND_USE, 4'd3);
        send_request(KIND_REMOVE, 4'd3);
        send_request(KIND_REMOVE, 4'd10);
        // Clean head goes first; the replace must rotate past flagged heads.
        send_request(KIND_EVICT, 4'd0);
        send_request(KIND_REPLACE, 4'd0);
        send_request(KIND_EVICT, 4'd0);
        send_request(KIND_EVICT, 4'd0);
        send_request(KIND_EVICT, 4'd0);
        send_request(KIND_INSERT, 4'd3);

        // Random requests in blocks of 20, each block with a traffic mix picked at random.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 20 == 0) mode = $urandom_range(MODE_FILL, MODE_MIXED);
            send_request(pick_kind(mode), 4'($urandom_range(0, ENTRIES - 1)));
        end
        s_tvalid <= 1'b0;

        // Let every outstanding result arrive, then allow the block to settle.
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
